FILE: rtl/mhcal_pkg.sv
// ----------------------------------------------------------------------------
// mhcal_pkg
// Shared widths, constants and types for the hard-iron calibration and
// moving-average magnetometer core.
// ----------------------------------------------------------------------------
package mhcal_pkg;

	localparam int WINDOW_DEPTH = 8;
	localparam int NAXIS        = 3;
	localparam int AX_X         = 0;
	localparam int AX_Y         = 1;
	localparam int AX_Z         = 2;

	localparam int SMP_W  = 16;
	localparam int MEAN_W = 17;
	localparam int DW     = $clog2(WINDOW_DEPTH);
	localparam int PTR_W  = (WINDOW_DEPTH > 1) ? DW : 1;
	localparam int SUM_W  = SMP_W + DW;
	localparam int MAG_W  = SUM_W;

	// floor(2^RSH / depth); the quotient it gives is low by at most one
	localparam int RSH    = MAG_W;
	localparam int RCP_W  = RSH + 1;
	localparam int PROD_W = MAG_W + RCP_W;
	localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << RSH) / WINDOW_DEPTH);

	typedef logic [7:0]               byte_t;
	typedef logic signed [SMP_W-1:0]  smp_t;
	typedef smp_t [NAXIS-1:0]         axes_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic [MAG_W-1:0]         mag_t;
	typedef logic [PROD_W-1:0]        prod_t;
	typedef logic signed [MEAN_W-1:0] mean_t;
	typedef logic [PTR_W-1:0]         ptr_t;

endpackage

FILE: rtl/mhcal_in_if.sv
// ----------------------------------------------------------------------------
// mhcal_in_if
// Sensor read channel: six raw bytes and the calibrate flag.
// ----------------------------------------------------------------------------
interface mhcal_in_if;
	import mhcal_pkg::*;

	logic  valid;
	logic  ready;
	byte_t x_high;
	byte_t x_low;
	byte_t z_high;
	byte_t z_low;
	byte_t y_high;
	byte_t y_low;
	logic  calibrate;

	modport source (
		output valid, x_high, x_low, z_high, z_low, y_high, y_low, calibrate,
		input  ready
	);
	modport sink (
		input  valid, x_high, x_low, z_high, z_low, y_high, y_low, calibrate,
		output ready
	);
endinterface

FILE: rtl/mhcal_out_if.sv
// ----------------------------------------------------------------------------
// mhcal_out_if
// Result channel: offset-corrected window means and the new-offsets flag.
// ----------------------------------------------------------------------------
interface mhcal_out_if;
	import mhcal_pkg::*;

	logic  valid;
	logic  ready;
	mean_t mean_x;
	mean_t mean_y;
	mean_t mean_z;
	logic  offsets_new;

	modport source (
		output valid, mean_x, mean_y, mean_z, offsets_new,
		input  ready
	);
	modport sink (
		input  valid, mean_x, mean_y, mean_z, offsets_new,
		output ready
	);
endinterface

FILE: rtl/mag_hard_iron_cal_moving_average_core.sv
// ----------------------------------------------------------------------------
// mag_hard_iron_cal_moving_average_core
// Hard-iron offset calibration and per-axis moving average for a
// three-axis magnetometer.
// ----------------------------------------------------------------------------
// Channels: "reading" takes one six-byte read (X, Z, Y big-endian pairs)
// plus the calibrate flag; "result" gives mean_x/y/z minus offset and
// offsets_new. A transfer happens when valid and ready are both high.
// Calibration reads only update the per-axis max/min and give no result.
// The first normal read after calibration loads the offsets and carries
// offsets_new = 1.
// Throughput: one read per cycle while the pipeline is not held by a stalled
// receiver. The window lives in one synchronous RAM (one word of three
// samples per slot): each read fetches its slot at the transfer and writes
// it back when it leaves the first stage, with forwarding when the same slot
// is hit back to back. Stages: RAM read at the transfer, running-sum update,
// reciprocal multiply, quotient select, correction into the output register.
// Stall: the pipeline stages hold while the receiver stalls; bubbles
// collapse, so reads are still taken while a result waits.
// Reset: control, sums, max/min/offsets clear; per-slot valid bits clear,
// so the window reads as zeros at once with no clearing pass.
// ----------------------------------------------------------------------------
module mag_hard_iron_cal_moving_average_core (
	input  logic       clk,
	input  logic       arst_n,
	mhcal_in_if.sink   reading,
	mhcal_out_if.source result
);
	import mhcal_pkg::*;

	// window RAM and slot valid bits
	axes_t                   win_mem [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0] win_vld_q;
	ptr_t                    wr_pos_q;

	// calibration state
	smp_t max_q [NAXIS];
	smp_t min_q [NAXIS];
	smp_t offset_q [NAXIS];
	logic was_cal_q;
	sum_t sum_q [NAXIS];

	// pipeline
	logic  vld_s1, vld_s2, vld_s3, vld_s4, out_vld_q;
	axes_t smp_s1, rd_s1;
	logic  rdv_s1;
	ptr_t  ptr_s1;
	smp_t  off_s1 [NAXIS];
	logic  fresh_s1;
	sum_t  sum_s2 [NAXIS];
	smp_t  off_s2 [NAXIS];
	logic  fresh_s2;
	prod_t prod_s3 [NAXIS];
	mag_t  mag_s3 [NAXIS];
	logic  neg_s3 [NAXIS];
	smp_t  off_s3 [NAXIS];
	logic  fresh_s3;
	mag_t  q0_s4 [NAXIS];
	mag_t  mag_s4 [NAXIS];
	logic  neg_s4 [NAXIS];
	smp_t  off_s4 [NAXIS];
	logic  fresh_s4;
	mean_t res_q [NAXIS];
	logic  fresh_q;

	logic load_out, load4, load3, load2;
	logic acc, acc_norm, acc_cal, fwd;
	ptr_t pos_nxt;

	axes_t smp_in;
	smp_t  base_max [NAXIS];
	smp_t  base_min [NAXIS];
	logic signed [SMP_W:0] msum [NAXIS];
	logic signed [SMP_W:0] mhalf [NAXIS];
	smp_t  off_nxt [NAXIS];
	smp_t  off_use [NAXIS];
	smp_t  old_smp [NAXIS];
	sum_t  sum_nxt [NAXIS];
	logic  neg_s2 [NAXIS];
	mag_t  mag_s2 [NAXIS];
	mag_t  prd_s4 [NAXIS];
	mag_t  rem_s4 [NAXIS];
	mag_t  quo_s4 [NAXIS];
	mean_t qm_s4 [NAXIS];
	mean_t res_s4 [NAXIS];

	// handshake chain, output side first
	assign load_out = vld_s4 && (!out_vld_q || result.ready);
	assign load4    = vld_s3 && (!vld_s4 || load_out);
	assign load3    = vld_s2 && (!vld_s3 || load4);
	assign load2    = vld_s1 && (!vld_s2 || load3);

	assign reading.ready = !vld_s1 || load2;
	assign acc      = reading.valid && reading.ready;
	assign acc_norm = acc && !reading.calibrate;
	assign acc_cal  = acc && reading.calibrate;

	assign pos_nxt = (wr_pos_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wr_pos_q + 1'b1;
	// the slot being written back is the one the new read fetches
	assign fwd = load2 && (ptr_s1 == wr_pos_q);

	assign smp_in[AX_X] = {reading.x_high, reading.x_low};
	assign smp_in[AX_Y] = {reading.y_high, reading.y_low};
	assign smp_in[AX_Z] = {reading.z_high, reading.z_low};

	always_comb begin
		for (int a = 0; a < NAXIS; a++) begin
			base_max[a] = was_cal_q ? max_q[a] : '0;
			base_min[a] = was_cal_q ? min_q[a] : '0;
			msum[a]     = {max_q[a][SMP_W-1], max_q[a]} + {min_q[a][SMP_W-1], min_q[a]};
			// halve, truncating toward zero
			mhalf[a]    = $signed(msum[a] + {{SMP_W{1'b0}}, msum[a][SMP_W]}) >>> 1;
			off_nxt[a]  = mhalf[a][SMP_W-1:0];
			off_use[a]  = was_cal_q ? off_nxt[a] : offset_q[a];

			old_smp[a]  = rdv_s1 ? $signed(rd_s1[a]) : '0;
			sum_nxt[a]  = sum_q[a] + SUM_W'($signed(smp_s1[a])) - SUM_W'(old_smp[a]);

			neg_s2[a]   = sum_s2[a][SUM_W-1];
			mag_s2[a]   = neg_s2[a] ? MAG_W'(-sum_s2[a]) : MAG_W'(sum_s2[a]);

			prd_s4[a]   = MAG_W'(q0_s4[a] * MAG_W'(WINDOW_DEPTH));
			rem_s4[a]   = mag_s4[a] - prd_s4[a];
			quo_s4[a]   = q0_s4[a] + MAG_W'(rem_s4[a] >= MAG_W'(WINDOW_DEPTH));
			qm_s4[a]    = MEAN_W'(quo_s4[a]);
			res_s4[a]   = (neg_s4[a] ? -qm_s4[a] : qm_s4[a]) - MEAN_W'(off_s4[a]);
		end
	end

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
			wr_pos_q  <= '0;
			win_vld_q <= '0;
			was_cal_q <= 1'b0;
			for (int a = 0; a < NAXIS; a++) begin
				max_q[a]    <= '0;
				min_q[a]    <= '0;
				offset_q[a] <= '0;
				sum_q[a]    <= '0;
			end
		end else begin
			if (acc_norm)
				vld_s1 <= 1'b1;
			else if (load2)
				vld_s1 <= 1'b0;
			if (load2)
				vld_s2 <= 1'b1;
			else if (load3)
				vld_s2 <= 1'b0;
			if (load3)
				vld_s3 <= 1'b1;
			else if (load4)
				vld_s3 <= 1'b0;
			if (load4)
				vld_s4 <= 1'b1;
			else if (load_out)
				vld_s4 <= 1'b0;
			if (load_out)
				out_vld_q <= 1'b1;
			else if (result.ready)
				out_vld_q <= 1'b0;

			if (acc_norm)
				wr_pos_q <= pos_nxt;
			if (load2) begin
				win_vld_q[ptr_s1] <= 1'b1;
				for (int a = 0; a < NAXIS; a++)
					sum_q[a] <= sum_nxt[a];
			end

			if (acc_cal) begin
				was_cal_q <= 1'b1;
				// else-if: only one of max and min moves
				for (int a = 0; a < NAXIS; a++) begin
					if ($signed(smp_in[a]) > base_max[a]) begin
						max_q[a] <= smp_in[a];
						min_q[a] <= base_min[a];
					end else if ($signed(smp_in[a]) < base_min[a]) begin
						max_q[a] <= base_max[a];
						min_q[a] <= smp_in[a];
					end else begin
						max_q[a] <= base_max[a];
						min_q[a] <= base_min[a];
					end
				end
			end else if (acc_norm) begin
				was_cal_q <= 1'b0;
				for (int a = 0; a < NAXIS; a++)
					offset_q[a] <= off_use[a];
			end
		end
	end

	// RAM and payload registers
	always_ff @(posedge clk) begin
		if (load2)
			win_mem[ptr_s1] <= smp_s1;
		if (acc_norm) begin
			rd_s1    <= fwd ? smp_s1 : win_mem[wr_pos_q];
			rdv_s1   <= fwd || win_vld_q[wr_pos_q];
			smp_s1   <= smp_in;
			ptr_s1   <= wr_pos_q;
			fresh_s1 <= was_cal_q;
			for (int a = 0; a < NAXIS; a++)
				off_s1[a] <= off_use[a];
		end
		if (load2) begin
			fresh_s2 <= fresh_s1;
			for (int a = 0; a < NAXIS; a++) begin
				sum_s2[a] <= sum_nxt[a];
				off_s2[a] <= off_s1[a];
			end
		end
		if (load3) begin
			fresh_s3 <= fresh_s2;
			for (int a = 0; a < NAXIS; a++) begin
				prod_s3[a] <= PROD_W'(mag_s2[a]) * PROD_W'(RECIP);
				mag_s3[a]  <= mag_s2[a];
				neg_s3[a]  <= neg_s2[a];
				off_s3[a]  <= off_s2[a];
			end
		end
		if (load4) begin
			fresh_s4 <= fresh_s3;
			for (int a = 0; a < NAXIS; a++) begin
				q0_s4[a]  <= prod_s3[a][RSH +: MAG_W];
				mag_s4[a] <= mag_s3[a];
				neg_s4[a] <= neg_s3[a];
				off_s4[a] <= off_s3[a];
			end
		end
		if (load_out) begin
			fresh_q <= fresh_s4;
			for (int a = 0; a < NAXIS; a++)
				res_q[a] <= res_s4[a];
		end
	end

	assign result.valid       = out_vld_q;
	assign result.mean_x      = res_q[AX_X];
	assign result.mean_y      = res_q[AX_Y];
	assign result.mean_z      = res_q[AX_Z];
	assign result.offsets_new = fresh_q;

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_pos_q <= PTR_W'(WINDOW_DEPTH - 1))
		else $error("window write position out of range");

	a_fill_s1: assert property (@(posedge clk) disable iff (!arst_n)
		acc_norm |=> vld_s1)
		else $error("normal read transfer did not enter stage 1");

	a_cal_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		acc_cal |=> $stable(wr_pos_q))
		else $error("calibration read moved the window position");

	a_envelope: assert property (@(posedge clk) disable iff (!arst_n)
		max_q[AX_X] >= 0 && min_q[AX_X] <= 0 &&
		max_q[AX_Y] >= 0 && min_q[AX_Y] <= 0 &&
		max_q[AX_Z] >= 0 && min_q[AX_Z] <= 0)
		else $error("max/min envelope does not bracket zero");

endmodule
